### design/front_middle_back_queue_unit_assert.svh
// Assertion macros shared by the queue checker.
`ifndef FRONT_MIDDLE_BACK_QUEUE_UNIT_ASSERT_SVH
`define FRONT_MIDDLE_BACK_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMBQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FMBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/fmbq_pkg.sv
// Package with beat types, operation codes and constants of the queue.
`timescale 1ns / 1ps

package fmbq_pkg;

	// Default capacity of the queue.
	localparam int DEPTH_DEFAULT = 16;

	// Operation codes.
	localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
	localparam logic [2:0] OP_PUSH_MIDDLE = 3'd1;
	localparam logic [2:0] OP_PUSH_BACK   = 3'd2;
	localparam logic [2:0] OP_POP_FRONT   = 3'd3;
	localparam logic [2:0] OP_POP_MIDDLE  = 3'd4;
	localparam logic [2:0] OP_POP_BACK    = 3'd5;

	// Value returned by a pop that finds the queue empty.
	localparam logic signed [31:0] POP_EMPTY_VALUE = -32'sd1;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic               was_empty;
		logic               was_full;
		logic [4:0]         occupancy;
	} out_beat_t;

endpackage

### design/front_middle_back_queue_unit.sv
// Top level of the front/middle/back queue with its ordered shift store.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------
//  in      | input     | in_valid, in_stall  | in_beat_t
//  out     | output    | out_valid, out_stall| out_beat_t
//
// Each beat is taken into an input register and applied to the store once the
// output register is free; the entries from the chosen position on shift by one
// place in parallel and the result is loaded into the output register at that
// same edge. One beat per cycle is sustained while out is not stalled. Reset
// clears the count and the valid flags at once. A stall on out holds the output
// register and, once the input register is full, raises in_stall.
`timescale 1ns / 1ps

module front_middle_back_queue_unit
	import fmbq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                      valid_s1;
	in_beat_t                  beat_s1;
	logic                      out_valid_q;
	out_beat_t                 out_data_q;
	logic [CW-1:0]             count_q;
	logic signed [31:0]        entries_q [DEPTH];

	logic                      out_free;
	logic                      fire;
	logic [CW-1:0]             pos;
	logic                      do_ins;
	logic                      do_rem;
	logic                      full;
	logic                      empty;
	logic [CW-1:0]             count_d;
	logic signed [31:0]        entries_d [DEPTH];
	out_beat_t                 result;
	logic [31:0]               occ_ext;

	// Output register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// Decode the operation into a position and the kind of shift, then form
	// the new count and its report on the narrow occupancy field.
	always_comb begin
		pos                 = '0;
		do_ins              = 1'b0;
		do_rem              = 1'b0;
		result.popped_value = '0;
		result.was_empty    = 1'b0;
		result.was_full     = 1'b0;
		case (beat_s1.operation)
			OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
				if (full) begin
					result.was_full = 1'b1;
				end else begin
					do_ins = 1'b1;
					if (beat_s1.operation == OP_PUSH_MIDDLE) begin
						pos = count_q >> 1;
					end else if (beat_s1.operation == OP_PUSH_BACK) begin
						pos = count_q;
					end
				end
			end
			OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
				if (empty) begin
					result.popped_value = POP_EMPTY_VALUE;
					result.was_empty    = 1'b1;
				end else begin
					do_rem = 1'b1;
					if (beat_s1.operation == OP_POP_MIDDLE) begin
						pos = (count_q - CW'(1)) >> 1;
					end else if (beat_s1.operation == OP_POP_BACK) begin
						pos = count_q - CW'(1);
					end
					result.popped_value = entries_q[pos[IW-1:0]];
				end
			end
			default: begin
			end
		endcase
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_rem) begin
			count_d = count_q - CW'(1);
		end
		occ_ext          = 32'(count_d);
		result.occupancy = occ_ext[4:0];
	end

	// The entries from the chosen position on shift by one place; those before it stay.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			entries_d[i] = entries_q[i];
			if (do_ins && CW'(i) == pos) begin
				entries_d[i] = beat_s1.value;
			end
		end
		for (int i = 1; i < DEPTH; i++) begin
			if (do_ins && CW'(i) > pos) begin
				entries_d[i] = entries_q[i - 1];
			end
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (do_rem && CW'(i) >= pos) begin
				entries_d[i] = entries_q[i + 1];
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				count_q <= count_d;
			end
		end
	end

	// Payload registers and the store.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_data;
		end
		if (fire) begin
			out_data_q <= result;
			entries_q  <= entries_d;
		end
	end

endmodule

### design/fmbq_checker.sv
// Port-level checker of the queue and its bind to the top level.
`timescale 1ns / 1ps
`include "front_middle_back_queue_unit_assert.svh"

module fmbq_checker
	import fmbq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	logic in_take;
	logic out_held;
	logic empty_ok;
	logic full_ok;

	// Handshake terms and the expected shape of flagged result beats.
	assign in_take  = in_valid && !in_stall;
	assign out_held = out_valid && out_stall;
	assign empty_ok = (out_data.popped_value == POP_EMPTY_VALUE) &&
		(out_data.occupancy == 5'd0) && !out_data.was_full;
	assign full_ok  = (out_data.popped_value == 32'sd0) && !out_data.was_empty;

	// A stalled result beat stays valid and unchanged.
	`FMBQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid && $stable(out_data), "held beat changed")

	// A fresh result follows an accepted input beat that passed the input register.
	`FMBQ_ASSERT_NOW(a_out_from_in, clk, arst_n, $rose(out_valid), $past(in_take, 2), "result without input")

	// An empty pop reports the marker value and an empty queue.
	`FMBQ_ASSERT_NOW(a_empty_pop, clk, arst_n, out_valid && out_data.was_empty, empty_ok, "bad empty pop")

	// A dropped push reports a zero value.
	`FMBQ_ASSERT_NOW(a_full_push, clk, arst_n, out_valid && out_data.was_full, full_ok, "bad dropped push")

endmodule

bind front_middle_back_queue_unit fmbq_checker u_fmbq_checker (.*);
